// ----- src/md5_digest_engine_macros.svh -----
// Assertion macros shared by the checker
`ifndef MD5_DIGEST_ENGINE_MACROS_SVH
`define MD5_DIGEST_ENGINE_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define MD5_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/md5_pkg.sv -----
`timescale 1ns / 1ps
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_item;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } md5_out_t;

    // Work handed from the front end to the compression back end
    typedef enum logic [1:0] {
        JOB_BLOCK = 2'd0,
        JOB_FINAL = 2'd1
    } md5_job_kind_t;

    typedef struct packed {
        md5_job_kind_t  kind;
        logic [511:0]   block;
    } md5_job_t;

    localparam int unsigned QueueDepth = 2;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] STEP_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        logic [4:0] r;
        r = 5'd0;
        unique case ({step[5:4], step[1:0]})
            4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
            4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
            4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
            4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; 4'hf: r = 5'd21;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] s;
        logic [3:0] g;
        s = step[3:0];
        g = s;
        unique case (step[5:4])
            2'd0: g = s;
            2'd1: g = 4'((s << 2) + s + 4'd1);
            2'd2: g = 4'((s << 1) + s + 4'd5);
            2'd3: g = 4'((s << 3) - s);
            default: g = s;
        endcase
        return g;
    endfunction

endpackage

// ----- src/md5_digest_engine.sv -----
`timescale 1ns / 1ps
// MD5 engine taking one message byte per transfer; a transfer with last_item set
// closes the message and one digest transfer follows. Bytes are taken one a cycle
// while the block buffer fills and no full block waits; each full 64-byte block
// then runs through the one-step-per-cycle compression core, and a final item
// adds one or two such blocks. A two-entry block queue lets the byte side fill
// the next block while the core works; the digest waits in an output register.
module md5_digest_engine #(
    parameter int unsigned QUEUE_DEPTH = md5_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  md5_pkg::md5_in_t   in_data,
    input  logic               in_valid,
    output logic               in_ready,
    output md5_pkg::md5_out_t  out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    md5_pkg::md5_job_t fq_data, qc_data;
    logic fq_valid, fq_ready, qc_valid, qc_ready;

    md5_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
        .job_data(fq_data), .job_valid(fq_valid), .job_ready(fq_ready)
    );

    md5_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_data(fq_data), .wr_valid(fq_valid), .wr_ready(fq_ready),
        .rd_data(qc_data), .rd_valid(qc_valid), .rd_ready(qc_ready)
    );

    md5_core u_core (
        .clk(clk), .rst_n(rst_n),
        .job_data(qc_data), .job_valid(qc_valid), .job_ready(qc_ready),
        .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
    );
endmodule

// ----- src/md5_front.sv -----
`timescale 1ns / 1ps
// Packs bytes into blocks and emits padded final blocks
module md5_front (
    input  logic                clk,
    input  logic                rst_n,
    input  md5_pkg::md5_in_t    in_data,
    input  logic                in_valid,
    output logic                in_ready,
    output md5_pkg::md5_job_t   job_data,
    output logic                job_valid,
    input  logic                job_ready
);
    typedef enum logic [1:0] {
        FR_ABSORB,
        FR_PAD2,
        FR_HOLD
    } fr_state_t;

    fr_state_t     state_reg, state_next;
    logic [31:0]   words_reg [16];
    logic [63:0]   count_reg;
    logic          pend_reg;
    md5_pkg::md5_job_t job_reg;

    logic [5:0]    pos_byte;
    logic [5:0]    pos_pad;
    logic [63:0]   count_inc;
    logic [63:0]   bits;
    logic [511:0]  cur_block;
    logic [511:0]  pad_block;
    logic          accept;
    logic          wrap_last;
    logic          two_blk;

    assign in_ready  = (state_reg == FR_ABSORB) && !pend_reg;
    assign accept    = in_valid && in_ready;
    assign job_valid = pend_reg;
    assign job_data  = job_reg;
    assign pos_byte  = count_reg[5:0];
    assign count_inc = count_reg + 64'((in_data.byte_valid) ? 1 : 0);
    assign pos_pad   = count_inc[5:0];
    assign bits      = {count_inc[60:0], 3'b000};
    // A byte that completes the block sends the whole padding to a second block
    assign wrap_last = in_data.byte_valid && (pos_byte == 6'd63);
    assign two_blk   = (pos_pad >= 6'd56) || wrap_last;

    always_comb
    begin
        for (int w = 0; w < 16; w++)
        begin
            cur_block[w*32 +: 32] = words_reg[w];
        end
        if (in_data.byte_valid)
        begin
            cur_block[pos_byte*8 +: 8] = in_data.data_byte;
        end
        pad_block = cur_block;
        pad_block[pos_pad*8 +: 8] = md5_pkg::PAD_BYTE;
        for (int b = 0; b < 64; b++)
        begin
            if (6'(b) > pos_pad)
            begin
                pad_block[b*8 +: 8] = 8'h00;
            end
        end
        if (pos_pad < 6'd56)
        begin
            pad_block[511:448] = bits;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        priority case (state_reg)
            FR_ABSORB: if (accept && in_data.last_item)
                           state_next = two_blk ? FR_PAD2 : FR_HOLD;
            FR_PAD2:   if (!pend_reg) state_next = FR_HOLD;
            FR_HOLD:   if (!pend_reg) state_next = FR_ABSORB;
            default:   state_next = FR_ABSORB;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_ABSORB;
            count_reg <= 64'd0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pend_reg && job_ready)
            begin
                pend_reg <= 1'b0;
            end
            if (accept)
            begin
                count_reg <= in_data.last_item ? 64'd0 : count_inc;
                if (in_data.last_item)
                begin
                    pend_reg <= 1'b1;
                end
                else if (in_data.byte_valid && pos_byte == 6'd63)
                begin
                    pend_reg <= 1'b1;
                end
            end
            else if (state_reg == FR_PAD2 && !pend_reg)
            begin
                pend_reg <= 1'b1;
            end
        end
    end

    // Buffer and job writes; second pad block: 0x80 if wrapped, zeros, length
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (in_data.last_item)
            begin
                job_reg.block <= wrap_last ? cur_block : pad_block;
                job_reg.kind  <= two_blk ? md5_pkg::JOB_BLOCK
                                         : md5_pkg::JOB_FINAL;
                words_reg[0]  <= wrap_last ? {24'd0, md5_pkg::PAD_BYTE} : 32'd0;
                words_reg[14] <= bits[31:0];
                words_reg[15] <= bits[63:32];
            end
            else if (in_data.byte_valid)
            begin
                job_reg.block <= cur_block;
                job_reg.kind  <= md5_pkg::JOB_BLOCK;
                words_reg[pos_byte[5:2]][pos_byte[1:0]*8 +: 8] <= in_data.data_byte;
            end
        end
        else if (state_reg == FR_PAD2 && !pend_reg)
        begin
            job_reg.block <= {words_reg[15], words_reg[14], 416'd0, words_reg[0]};
            job_reg.kind  <= md5_pkg::JOB_FINAL;
        end
    end
endmodule

// ----- src/md5_queue.sv -----
`timescale 1ns / 1ps
// Short FIFO between front end and compression core
module md5_queue #(
    parameter int unsigned DEPTH = md5_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  md5_pkg::md5_job_t  wr_data,
    input  logic               wr_valid,
    output logic               wr_ready,
    output md5_pkg::md5_job_t  rd_data,
    output logic               rd_valid,
    input  logic               rd_ready
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    md5_pkg::md5_job_t  mem [DEPTH];
    logic [AW-1:0]      wp_reg, rp_reg;
    logic [AW:0]        cnt_reg;
    logic               wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem[wp_reg] <= wr_data;
    end
endmodule

// ----- src/md5_core.sv -----
`timescale 1ns / 1ps
// 64-step compression, one step a cycle; holds chain value and result
module md5_core (
    input  logic                clk,
    input  logic                rst_n,
    input  md5_pkg::md5_job_t   job_data,
    input  logic                job_valid,
    output logic                job_ready,
    output md5_pkg::md5_out_t   out_data,
    output logic                out_valid,
    input  logic                out_ready
);
    typedef enum logic [1:0] {
        CO_IDLE,
        CO_RUN,
        CO_ADD
    } co_state_t;

    co_state_t    state_reg;
    logic [31:0]  chain_reg [4];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [5:0]   step_reg;
    logic [511:0] blk_reg;
    logic         fin_reg;
    logic         ov_reg;
    md5_pkg::md5_out_t res_reg;

    logic [31:0] f, t, m, rot;
    logic [4:0]  s;
    logic [31:0] na, nb, nc, nd;

    assign job_ready = (state_reg == CO_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        unique case (step_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            2'd3: f = c_reg ^ (b_reg | ~d_reg);
            default: f = '0;
        endcase
        m   = blk_reg[md5_pkg::msg_index(step_reg)*32 +: 32];
        t   = a_reg + f + md5_pkg::STEP_CONST[step_reg] + m;
        s   = md5_pkg::rot_amount(step_reg);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
        na  = chain_reg[0] + a_reg;
        nb  = chain_reg[1] + b_reg;
        nc  = chain_reg[2] + c_reg;
        nd  = chain_reg[3] + d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CO_IDLE;
            step_reg     <= '0;
            ov_reg       <= 1'b0;
            chain_reg[0] <= md5_pkg::IV_A;
            chain_reg[1] <= md5_pkg::IV_B;
            chain_reg[2] <= md5_pkg::IV_C;
            chain_reg[3] <= md5_pkg::IV_D;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            unique case (state_reg)
                CO_IDLE:
                    if (job_valid && job_ready)
                    begin
                        a_reg <= chain_reg[0]; b_reg <= chain_reg[1];
                        c_reg <= chain_reg[2]; d_reg <= chain_reg[3];
                        fin_reg   <= (job_data.kind == md5_pkg::JOB_FINAL);
                        step_reg  <= '0;
                        state_reg <= CO_RUN;
                    end
                CO_RUN:
                begin
                    a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg;
                    b_reg <= b_reg + rot;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd63) state_reg <= CO_ADD;
                end
                CO_ADD:
                begin
                    state_reg <= CO_IDLE;
                    if (fin_reg)
                    begin
                        res_reg.digest_low  <= {nb, na};
                        res_reg.digest_high <= {nd, nc};
                        ov_reg <= 1'b1;
                        chain_reg[0] <= md5_pkg::IV_A;
                        chain_reg[1] <= md5_pkg::IV_B;
                        chain_reg[2] <= md5_pkg::IV_C;
                        chain_reg[3] <= md5_pkg::IV_D;
                    end
                    else
                    begin
                        chain_reg[0] <= na; chain_reg[1] <= nb;
                        chain_reg[2] <= nc; chain_reg[3] <= nd;
                    end
                end
                default: state_reg <= CO_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CO_IDLE && job_valid && job_ready) blk_reg <= job_data.block;
    end
endmodule

// ----- src/md5_checker.sv -----
`timescale 1ns / 1ps
`include "md5_digest_engine_macros.svh"
module md5_checker (
    input logic              clk,
    input logic              rst_n,
    input md5_pkg::md5_in_t  in_data,
    input logic              in_valid,
    input logic              in_ready,
    input md5_pkg::md5_out_t out_data,
    input logic              out_valid,
    input logic              out_ready
);
    `MD5_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "digest dropped while stalled")
    `MD5_ASSERT_NEXT(a_last_blocks, clk, rst_n, in_valid && in_ready && in_data.last_item, !in_ready, "input taken straight after final transfer")
    `MD5_ASSERT_IMPL(a_out_known, clk, rst_n, out_valid, !$isunknown(out_data), "digest has unknown bits")
endmodule

bind md5_digest_engine md5_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
);

// ----- dv/md5_digest_engine_tb.sv -----
`timescale 1ns / 1ps
module md5_digest_engine_tb;

    logic               clk;
    logic               rst_n;
    md5_pkg::md5_in_t   in_data;
    logic               in_valid;
    logic               in_ready;
    md5_pkg::md5_out_t  out_data;
    logic               out_valid;
    logic               out_ready;

    md5_digest_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // predictor state
    logic [31:0] chain_q [4];
    logic [31:0] blk_q [16];
    logic [63:0] msg_bytes;

    md5_pkg::md5_in_t  byte_queue [$];
    md5_pkg::md5_out_t digest_queue [$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_cycles;
    int unsigned errors;
    int unsigned digests_seen;
    int unsigned items_sent;
    bit          stim_done;
    bit          in_taken = 1'b0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic int unsigned shift_for(input int unsigned step);
        int unsigned tbl [16];
        tbl = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        return tbl[(step / 16) * 4 + (step % 4)];
    endfunction

    task automatic compress_chain();
        logic [31:0] a, b, c, d, f, t;
        int unsigned g;
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (int unsigned i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = a + f + md5_pkg::STEP_CONST[i] + blk_q[g];
            a = d;
            d = c;
            c = b;
            b = b + rotl(t, shift_for(i));
        end
        chain_q[0] += a;
        chain_q[1] += b;
        chain_q[2] += c;
        chain_q[3] += d;
    endtask

    task automatic insert_byte(input int unsigned pos, input logic [7:0] v);
        if (pos % 4 == 0)
            blk_q[pos / 4] = {24'd0, v};
        else
            blk_q[pos / 4][8 * (pos % 4) +: 8] = v;
    endtask

    task automatic reload_chain();
        chain_q = '{md5_pkg::IV_A, md5_pkg::IV_B, md5_pkg::IV_C, md5_pkg::IV_D};
        msg_bytes = '0;
    endtask

    task automatic predict_digest(input md5_pkg::md5_in_t it);
        int unsigned pos;
        logic [63:0] bits;
        if (it.byte_valid)
        begin
            pos = msg_bytes[5:0];
            insert_byte(pos, it.data_byte);
            msg_bytes++;
            if (pos == 63)
                compress_chain();
        end
        if (it.last_item)
        begin
            pos = msg_bytes[5:0];
            insert_byte(pos, md5_pkg::PAD_BYTE);
            for (int unsigned w = pos / 4 + 1; w < 16; w++)
                blk_q[w] = '0;
            if (pos >= 56)
            begin
                compress_chain();
                for (int unsigned w = 0; w < 16; w++)
                    blk_q[w] = '0;
            end
            bits = msg_bytes << 3;
            blk_q[14] = bits[31:0];
            blk_q[15] = bits[63:32];
            compress_chain();
            digest_queue.push_back('{digest_high: {chain_q[3], chain_q[2]},
                                     digest_low: {chain_q[1], chain_q[0]}});
            reload_chain();
        end
    endtask

    // driver; advance only once the previous rising edge saw the transfer
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_taken)
        begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= byte_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // transfer accounting; in_ready sampled at the rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            predict_digest(in_data);
            items_sent++;
        end
    end

    // receiver ready
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_cycles != 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        md5_pkg::md5_out_t exp_d;
        if (rst_n && out_valid && out_ready)
        begin
            digests_seen++;
            if (digest_queue.size() == 0)
            begin
                $error("digest transfer with none expected: %h", out_data);
                errors++;
            end
            else
            begin
                exp_d = digest_queue.pop_front();
                if (out_data.digest_low !== exp_d.digest_low)
                begin
                    $error("digest_low expected %h actual %h",
                           exp_d.digest_low, out_data.digest_low);
                    errors++;
                end
                if (out_data.digest_high !== exp_d.digest_high)
                begin
                    $error("digest_high expected %h actual %h",
                           exp_d.digest_high, out_data.digest_high);
                    errors++;
                end
            end
        end
    end

    task automatic queue_item(input logic [7:0] v, input bit bv, input bit lst);
        md5_pkg::md5_in_t it;
        it.data_byte  = v;
        it.byte_valid = bv;
        it.last_item  = lst;
        byte_queue.push_back(it);
    endtask

    // message of len bytes; the final byte optionally rides with the end flag
    task automatic queue_message(input int unsigned len, input bit end_on_byte,
                                 input int unsigned noise_pct);
        for (int unsigned i = 0; i < len; i++)
        begin
            while ($urandom_range(99) < noise_pct)
                queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
            queue_item(8'($urandom_range(255)), 1'b1, end_on_byte && i == len - 1);
        end
        if (!end_on_byte || len == 0)
            queue_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic drain_all();
        while (byte_queue.size() != 0 || in_valid || digest_queue.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        int unsigned lens [9];
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        errors = 0;
        digests_seen = 0;
        items_sent = 0;
        stim_done = 0;
        for (int unsigned w = 0; w < 16; w++)
            blk_q[w] = '0;
        reload_chain();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, extreme bytes, ignored items, padding edges
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b1);
        queue_item(8'ha5, 1'b1, 1'b1);
        drain_all();
        lens = '{55, 56, 63, 64, 65, 119, 120, 128, 3};
        foreach (lens[i])
            queue_message(lens[i], 1'(i % 2), 0);
        drain_all();

        // long receiver hold-off while bytes keep coming
        hold_off_cycles = 600;
        for (int k = 0; k < 8; k++)
            queue_message($urandom_range(70), 1'($urandom_range(1)), 0);
        drain_all();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int k = 0; k < 6; k++)
                queue_message($urandom_range(9) == 0 ? $urandom_range(200)
                                                     : $urandom_range(40),
                              1'($urandom_range(1)), $urandom_range(1) ? 10 : 0);
            drain_all();
        end
        stim_done = 1;
        repeat (400) @(posedge clk);
        $display("Covered %0d input transfers and %0d digests, messages 0..200 bytes,",
                 items_sent, digests_seen);
        $display("padding boundaries, idle items and both-sided stalls.");
        if (errors == 0 && digest_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/md5_pkg.sv
src/md5_front.sv
src/md5_queue.sv
src/md5_core.sv
src/md5_digest_engine.sv
src/md5_checker.sv
dv/md5_digest_engine_tb.sv
